/* hdl/bpk_pkg.sv */
package bpk_pkg;

    localparam int MAX_WORDS_DEF = 1024;

    localparam int CAP_W     = 11;
    localparam int WORD_W    = 32;
    localparam int SLOT_W    = 10;
    localparam int TOTAL_W   = 16;
    localparam int COUNT_W   = 6;
    localparam int SCR_W     = 64;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_ALIGN   = 2'd1,
        CMD_FLUSH   = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

    // last member sits in the lowest bits, matching the tdata layout
    typedef struct packed {
        logic [COUNT_W-1:0] bit_count;
        logic [WORD_W-1:0]  value;
        cmd_t               cmd;
    } item_t;

    typedef struct packed {
        logic               overflow_flag;
        logic [TOTAL_W-1:0] total_bits;
        status_t            status;
        logic [SLOT_W-1:0]  word_slot;
        logic [WORD_W-1:0]  word_data;
        logic               word_valid;
    } result_t;

    localparam int RES_W = $bits(result_t);

endpackage

/* hdl/bpk_in_reg.sv */
module bpk_in_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  bpk_pkg::item_t s_item,
    input  logic          take,
    output logic          in_vld,
    output bpk_pkg::item_t in_item
);

    logic           vld_reg;
    bpk_pkg::item_t item_reg;

    assign s_tready = !vld_reg || take;
    assign in_vld   = vld_reg;
    assign in_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_tready) begin
            vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

/* hdl/bpk_core.sv */
module bpk_core #(
    parameter int MAX_WORDS = bpk_pkg::MAX_WORDS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [bpk_pkg::CAP_W-1:0] cap_cfg,
    input  logic                     in_vld,
    input  bpk_pkg::item_t           item,
    input  logic                     out_free,
    output logic                     take,
    output bpk_pkg::result_t         res
);

    localparam int WCW  = $clog2(MAX_WORDS + 1);
    localparam int BAW  = $clog2(MAX_WORDS * 32 + 1);
    localparam int CMPW = BAW + 1;

    logic [bpk_pkg::SCR_W-1:0] scratch_reg, scratch_next;
    logic [5:0]                pos_reg, pos_next;
    logic [WCW-1:0]            wc_reg, wc_next;
    logic [BAW-1:0]            ba_reg, ba_next;
    logic                      ovf_reg, ovf_next;

    logic [31:0]               cfg_ext, cap_clamp;
    logic [WCW-1:0]            cap_w;
    logic [CMPW-1:0]           capbits, ba_ext, ba_sum;
    logic [2:0]                rem;
    logic [bpk_pkg::COUNT_W-1:0] n_sat, wr_n;
    logic [bpk_pkg::WORD_W-1:0]  wr_val;
    logic [bpk_pkg::SCR_W-1:0] mask64, val64, sh64, scr_or;
    logic [6:0]                sh_amt, pos_sum;
    logic                      wr_go;

    assign take = in_vld && out_free;
    assign rem  = ba_reg[2:0];

    // effective capacity: zero acts as one, clamp at MAX_WORDS
    always_comb begin
        cfg_ext   = 32'(cap_cfg);
        cap_clamp = (cfg_ext == 32'd0) ? 32'd1 : cfg_ext;
        if (cap_clamp > 32'(MAX_WORDS)) begin
            cap_clamp = 32'(MAX_WORDS);
        end
        cap_w   = WCW'(cap_clamp);
        capbits = CMPW'({cap_w, 5'b0});
    end

    // shared write path, also used by align with zero padding
    always_comb begin
        n_sat  = (item.bit_count > 6'd32) ? 6'd32 : item.bit_count;
        wr_val = item.value;
        wr_n   = n_sat;
        if (item.cmd == bpk_pkg::CMD_ALIGN) begin
            wr_val = '0;
            wr_n   = 6'd8 - {3'b0, rem};
        end
        wr_go   = (item.cmd == bpk_pkg::CMD_WRITE) ||
                  (item.cmd == bpk_pkg::CMD_ALIGN && rem != 3'd0);
        mask64  = (64'd1 << wr_n) - 64'd1;
        val64   = {32'b0, wr_val} & mask64;
        sh_amt  = 7'd64 - 7'(pos_reg) - 7'(wr_n);
        sh64    = val64 << sh_amt;
        scr_or  = scratch_reg | sh64;
        pos_sum = 7'(pos_reg) + 7'(wr_n);
        ba_ext  = CMPW'(ba_reg);
        ba_sum  = ba_ext + CMPW'(wr_n);
    end

    always_comb begin
        scratch_next = scratch_reg;
        pos_next     = pos_reg;
        wc_next      = wc_reg;
        ba_next      = ba_reg;
        ovf_next     = ovf_reg;
        res.word_valid = 1'b0;
        res.word_data  = '0;
        res.word_slot  = '0;
        res.status     = bpk_pkg::ST_OK;

        case (item.cmd)
            bpk_pkg::CMD_WRITE, bpk_pkg::CMD_ALIGN: begin
                if (wr_go) begin
                    if (ba_ext == capbits) begin
                        res.status = bpk_pkg::ST_FULL;
                    end else if (ba_sum > capbits) begin
                        ovf_next   = 1'b1;
                        res.status = bpk_pkg::ST_OVF;
                    end else begin
                        ovf_next = 1'b0;
                        ba_next  = BAW'(ba_sum);
                        if (pos_sum >= 7'd32) begin
                            scratch_next = {scr_or[31:0], 32'b0};
                            pos_next     = 6'(pos_sum - 7'd32);
                            if (wc_reg < cap_w) begin
                                res.word_valid = 1'b1;
                                res.word_data  = scr_or[63:32];
                                res.word_slot  = bpk_pkg::SLOT_W'(wc_reg);
                                wc_next        = wc_reg + WCW'(1);
                            end else begin
                                // word completed after a flush used the last slot
                                ovf_next   = 1'b1;
                                res.status = bpk_pkg::ST_OVF;
                            end
                        end else begin
                            scratch_next = scr_or;
                            pos_next     = 6'(pos_sum);
                        end
                    end
                end
            end
            bpk_pkg::CMD_FLUSH: begin
                // scratch and position stay, later writes refill the same word
                if (pos_reg != 6'd0) begin
                    if (wc_reg >= cap_w) begin
                        ovf_next   = 1'b1;
                        res.status = bpk_pkg::ST_OVF;
                    end else begin
                        res.word_valid = 1'b1;
                        res.word_data  = scratch_reg[63:32];
                        res.word_slot  = bpk_pkg::SLOT_W'(wc_reg);
                        wc_next        = wc_reg + WCW'(1);
                    end
                end
            end
            bpk_pkg::CMD_RESTART: begin
                scratch_next = '0;
                pos_next     = '0;
                wc_next      = '0;
                ba_next      = '0;
                ovf_next     = 1'b0;
            end
            default: begin
            end
        endcase

        res.total_bits    = bpk_pkg::TOTAL_W'(ba_next);
        res.overflow_flag = ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scratch_reg <= '0;
            pos_reg     <= '0;
            wc_reg      <= '0;
            ba_reg      <= '0;
            ovf_reg     <= 1'b0;
        end else if (take) begin
            scratch_reg <= scratch_next;
            pos_reg     <= pos_next;
            wc_reg      <= wc_next;
            ba_reg      <= ba_next;
            ovf_reg     <= ovf_next;
        end
    end

endmodule

/* hdl/bpk_out_reg.sv */
module bpk_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  bpk_pkg::result_t res,
    output logic             free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output bpk_pkg::result_t m_res
);

    logic             vld_reg;
    bpk_pkg::result_t res_reg;

    assign free     = !vld_reg || m_tready;
    assign m_tvalid = vld_reg;
    assign m_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (free) begin
            vld_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

/* hdl/msb_first_bit_packer_core.sv */
// Packs fields of 1 to 32 bits, most significant bit first, into 32-bit words,
// one word on the input per cycle. Each input word is registered, evaluated
// combinationally against the packing state (64-bit scratch, bit position, slot
// and bit counters) and its single result is held in an output register, so a
// new word is taken every cycle while m_tready stays high; an accepted word
// goes through the input register, then the output register, to m_tvalid.
// Commands: 0 write bit_count bits of value,
// 1 pad with zeros to the next byte, 2 emit the pending partial word (bits are
// kept), 3 restart. Status 1 means the buffer is full, 2 means a write or word
// went past capacity_words (cfg_wr_data; 0 acts as 1, clamped at MAX_WORDS).
// Write the capacity only while no word is in flight.
module msb_first_bit_packer_core #(
    parameter int MAX_WORDS = bpk_pkg::MAX_WORDS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bpk_pkg::CAP_W-1:0]      cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cmd[1:0], value[33:2], bit_count[39:34]
    input  logic [bpk_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // word_valid[0], word_data[32:1], word_slot[42:33], status[44:43],
    // total_bits[60:45], overflow_flag[61], zero[63:62]
    output logic [bpk_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic [bpk_pkg::CAP_W-1:0] cap_reg;
    logic                      take, in_vld, out_free;
    bpk_pkg::item_t            in_item;
    bpk_pkg::result_t          res, m_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= bpk_pkg::CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    bpk_in_reg u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (bpk_pkg::item_t'(s_tdata)),
        .take     (take),
        .in_vld   (in_vld),
        .in_item  (in_item)
    );

    bpk_core #(
        .MAX_WORDS (MAX_WORDS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cap_cfg  (cap_reg),
        .in_vld   (in_vld),
        .item     (in_item),
        .out_free (out_free),
        .take     (take),
        .res      (res)
    );

    bpk_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = {(bpk_pkg::M_TDATA_W - bpk_pkg::RES_W)'(0), m_res};

endmodule

/* hdl/bpk_checker.sv */
module bpk_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bpk_pkg::M_TDATA_W-1:0] m_tdata
);

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // input only stalls behind a stalled output word
    a_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with the output free");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[44:43] != 2'd3 && m_tdata[63:62] == 2'b00)
        else $error("bad status code or padding");

    a_idle_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[42:1] == 42'd0)
        else $error("data or slot set without a word");

    // a refused write or lost word never emits and always flags overflow
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[44:43] == 2'd2 |-> m_tdata[61] && !m_tdata[0])
        else $error("overflow status inconsistent");

endmodule

bind msb_first_bit_packer_core bpk_checker u_bpk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
